>>> src/sspq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
package sspq_pkg;

  localparam int DEPTH        = 16;
  localparam int PRIO_BITS    = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int FILL_BITS    = $clog2(DEPTH + 1);

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    func_t                   func;
    logic [PRIO_BITS-1:0]    prio;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_word_t;

  typedef struct packed {
    status_t                 status;
    logic [PRIO_BITS-1:0]    out_prio;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    head_valid;
    logic [PRIO_BITS-1:0]    head_prio;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic [FILL_BITS-1:0]    fill;
  } out_word_t;

  // Contents of one storage cell.
  typedef struct packed {
    logic                    valid;
    logic [PRIO_BITS-1:0]    prio;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // Operation broadcast to every cell; enq and deq are already qualified.
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic [PRIO_BITS-1:0]    prio;
    logic [PAYLOAD_BITS-1:0] payload;
  } cell_cmd_t;

endpackage

>>> src/sspq_cell.sv
// One cell of the sorted chain: holds an entry and shifts with its neighbors.
module sspq_cell
  import sspq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    left_entry,
  input  logic      left_disp,
  input  entry_t    right_entry,
  output entry_t    entry_q,
  output entry_t    entry_nxt,
  output logic      disp
);

  entry_t entry_r;
  entry_t new_entry;

  assign new_entry = '{valid: 1'b1, prio: cmd.prio, payload: cmd.payload};

  // Strict compare keeps a new entry behind stored entries of equal priority.
  assign disp = entry_r.valid && (cmd.prio < entry_r.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.deq) begin
      entry_nxt = right_entry;
    end else if (cmd.enq) begin
      priority if (disp) begin
        entry_nxt = left_disp ? left_entry : new_entry;
      end else if (entry_r.valid) begin
        entry_nxt = entry_r;
      end else if (left_disp) begin
        entry_nxt = left_entry;
      end else if (left_entry.valid) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r.prio    <= entry_nxt.prio;
    entry_r.payload <= entry_nxt.payload;
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  assign entry_q = entry_r;

endmodule

>>> src/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built as a chain of cells.
//
// The queue holds up to DEPTH entries in ascending priority order in a chain
// of cells; equal priorities leave in arrival order. A word is accepted on any
// clock edge where start is high and busy is low, and busy never rises, so one
// operation is taken every cycle. Each operation produces exactly one result
// word, shown on out_word with out_valid high in the cycle after the
// accepting edge; the receiver must take it then. Every cell compares the new
// priority with its own entry and shifts toward the tail or the head in the
// same cycle, regardless of fill. Enqueue on a full queue is dropped with
// status full, dequeue on an empty queue reports status empty, and every
// result carries the head and fill after the step.
module stable_sorted_priority_queue
  import sspq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  entry_t    cell_q   [DEPTH];
  entry_t    cell_nxt [DEPTH];
  logic      cell_disp[DEPTH];
  cell_cmd_t cmd;

  logic [FILL_BITS-1:0] count_r, count_nxt;
  logic                 accept;
  logic                 is_full, is_empty;
  out_word_t            res_nxt, res_r;
  logic                 out_valid_r;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == FILL_BITS'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    cmd.enq     = accept && (in_word.func == FUNC_ENQ) && !is_full;
    cmd.deq     = accept && (in_word.func == FUNC_DEQ) && !is_empty;
    cmd.prio    = in_word.prio;
    cmd.payload = in_word.payload;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_d;
    if (i == 0) begin : g_first
      // The slot before the head acts as occupied and never displaced.
      assign left_e = '{valid: 1'b1, prio: '0, payload: '0};
      assign left_d = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_d = cell_disp[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = '{valid: 1'b0, prio: '0, payload: '0};
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end
    sspq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_entry (left_e),
      .left_disp  (left_d),
      .right_entry(right_e),
      .entry_q    (cell_q[i]),
      .entry_nxt  (cell_nxt[i]),
      .disp       (cell_disp[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + FILL_BITS'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - FILL_BITS'(1);
    end
  end

  always_comb begin
    res_nxt.status      = ST_OK;
    res_nxt.out_prio    = '0;
    res_nxt.out_payload = '0;
    if (in_word.func == FUNC_ENQ) begin
      if (is_full) begin
        res_nxt.status = ST_FULL;
      end
    end else if (is_empty) begin
      res_nxt.status = ST_EMPTY;
    end else begin
      res_nxt.out_prio    = cell_q[0].prio;
      res_nxt.out_payload = cell_q[0].payload;
    end
    res_nxt.head_valid   = cell_nxt[0].valid;
    res_nxt.head_prio    = cell_nxt[0].valid ? cell_nxt[0].prio : '0;
    res_nxt.head_payload = cell_nxt[0].valid ? cell_nxt[0].payload : '0;
    res_nxt.fill         = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = res_r;

endmodule
